// ===== rtl/programmable_crc_engine_assert.svh =====
// assertion macros for the programmable crc engine
// no dependencies; included by the top level
`ifndef PROGRAMMABLE_CRC_ENGINE_ASSERT_SVH
`define PROGRAMMABLE_CRC_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pce_pkg.sv =====
// types, codes and helper functions for the programmable crc engine
// no dependencies; used by every rtl file of the block but the assertion header
package pce_pkg;

	localparam logic [31:0] MASK16    = 32'h0000_FFFF;
	localparam logic [31:0] MASK32    = 32'hFFFF_FFFF;
	localparam logic [31:0] POLY_RST  = 32'h0000_1021;
	localparam int          IDX_W     = 3;
	localparam int          CNT_W     = 3;
	localparam logic [2:0]  MAX_BYTES = 3'd4;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDE_MODE  = 3'd0,
		REG_POLYNOMIAL = 3'd1,
		REG_SEED       = 3'd2,
		REG_WR_XPOSE   = 3'd3,
		REG_RD_XPOSE   = 3'd4,
		REG_COMPLEMENT = 3'd5
	} pce_reg_t;

	typedef enum logic [1:0] {
		XP_NONE       = 2'd0,
		XP_BITS       = 2'd1,
		XP_BITS_BYTES = 2'd2,
		XP_BYTES      = 2'd3
	} pce_xpose_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_FOLD = 1'b1
	} pce_state_t;

	typedef struct packed {
		logic        wide_mode;
		logic [31:0] polynomial;
		logic [31:0] seed_value;
		pce_xpose_t  write_transpose;
		pce_xpose_t  read_transpose;
		logic        complement_result;
	} pce_cfg_t;

	typedef struct packed {
		logic load;   // new word accepted
		logic start;  // seed load with this word
		logic step;   // fold one byte
	} pce_ctl_t;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	function automatic logic rev_bits(input pce_xpose_t t);
		return (t == XP_BITS) || (t == XP_BITS_BYTES);
	endfunction

	function automatic logic swap_bytes(input pce_xpose_t t);
		return (t == XP_BITS_BYTES) || (t == XP_BYTES);
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		return n[2] ? MAX_BYTES : n;
	endfunction

	// arrange the valid bytes in feed order, first byte in bits 31:24
	// three bytes go as a two-byte write then a one-byte write
	function automatic logic [31:0] order_bytes(input logic [31:0] w,
		input logic [CNT_W-1:0] n, input pce_xpose_t t);
		logic [7:0]  b0, b1, b2, b3;
		logic        sw;
		logic [31:0] r;
		b0 = rev_bits(t) ? rev8(w[7:0])   : w[7:0];
		b1 = rev_bits(t) ? rev8(w[15:8])  : w[15:8];
		b2 = rev_bits(t) ? rev8(w[23:16]) : w[23:16];
		b3 = rev_bits(t) ? rev8(w[31:24]) : w[31:24];
		sw = swap_bytes(t);
		case (n) inside
			3'd4, 3'd5, 3'd6, 3'd7: r = sw ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
			3'd3:                   r = sw ? {b0, b1, b2, 8'h00} : {b1, b0, b2, 8'h00};
			3'd2:                   r = sw ? {b0, b1, 16'h0000} : {b1, b0, 16'h0000};
			3'd1:                   r = {b0, 24'h000000};
			default:                r = '0;
		endcase
		return r;
	endfunction

	// one byte through the crc shift register, msb first
	function automatic logic [31:0] fold_byte(input logic [31:0] c,
		input logic [7:0] b, input logic [31:0] poly, input logic wide);
		logic [31:0] r;
		logic        fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = (wide ? r[31] : r[15]) ^ b[3'(7 - i)];
			r  = {r[30:0], 1'b0};
			if (!wide) begin
				r[31:16] = '0;
			end
			if (fb) begin
				r = r ^ poly;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] format_result(input logic [31:0] c,
		input pce_cfg_t cfg);
		logic [31:0] m;
		logic [31:0] v;
		logic [7:0]  b0, b1, b2, b3;
		logic [31:0] r;
		m  = cfg.wide_mode ? MASK32 : MASK16;
		v  = c & m;
		b0 = rev_bits(cfg.read_transpose) ? rev8(v[7:0])   : v[7:0];
		b1 = rev_bits(cfg.read_transpose) ? rev8(v[15:8])  : v[15:8];
		b2 = rev_bits(cfg.read_transpose) ? rev8(v[23:16]) : v[23:16];
		b3 = rev_bits(cfg.read_transpose) ? rev8(v[31:24]) : v[31:24];
		if (cfg.wide_mode) begin
			r = swap_bytes(cfg.read_transpose) ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
		end else begin
			r = swap_bytes(cfg.read_transpose) ? {16'h0000, b0, b1} : {16'h0000, b1, b0};
		end
		if (cfg.complement_result) begin
			r = r ^ m;
		end
		return r & m;
	endfunction

endpackage

// ===== rtl/pce_channels.sv =====
// valid/ready channel interfaces of the programmable crc engine
// depends on pce_pkg for the register index width

interface pce_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pce_pkg::IDX_W-1:0]     wr_index;
	logic [31:0]                   wr_data;
	modport source (output valid, wr_index, wr_data, input ready);
	modport sink (input valid, wr_index, wr_data, output ready);
endinterface

interface pce_in_if;
	logic                          valid;
	logic                          ready;
	logic                          start_block;
	logic [31:0]                   data_word;
	logic [pce_pkg::CNT_W-1:0]     byte_count;
	modport source (output valid, start_block, data_word, byte_count, input ready);
	modport sink (input valid, start_block, data_word, byte_count, output ready);
endinterface

interface pce_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;
	modport source (output valid, crc_value, input ready);
	modport sink (input valid, crc_value, output ready);
endinterface

// ===== rtl/pce_cfg_regs.sv =====
// configuration register file of the programmable crc engine
// depends on pce_pkg and the pce_cfg_if channel
module pce_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	pce_cfg_if.sink           cfg,
	output pce_pkg::pce_cfg_t regs
);

	pce_pkg::pce_cfg_t regs_q;
	logic              wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid & cfg.ready;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.wide_mode         <= 1'b0;
			regs_q.polynomial        <= pce_pkg::POLY_RST;
			regs_q.seed_value        <= '0;
			regs_q.write_transpose   <= pce_pkg::XP_NONE;
			regs_q.read_transpose    <= pce_pkg::XP_NONE;
			regs_q.complement_result <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg.wr_index)
				pce_pkg::REG_WIDE_MODE:  regs_q.wide_mode <= cfg.wr_data[0];
				pce_pkg::REG_POLYNOMIAL: regs_q.polynomial <= cfg.wr_data;
				pce_pkg::REG_SEED:       regs_q.seed_value <= cfg.wr_data;
				pce_pkg::REG_WR_XPOSE:
					regs_q.write_transpose <= pce_pkg::pce_xpose_t'(cfg.wr_data[1:0]);
				pce_pkg::REG_RD_XPOSE:
					regs_q.read_transpose <= pce_pkg::pce_xpose_t'(cfg.wr_data[1:0]);
				pce_pkg::REG_COMPLEMENT: regs_q.complement_result <= cfg.wr_data[0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

endmodule

// ===== rtl/pce_byte_shifter.sv =====
// byte shift register that feeds the crc core one byte per cycle
// depends on pce_pkg for byte ordering and control types
module pce_byte_shifter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pce_pkg::pce_ctl_t           ctl,
	input  logic [31:0]                 data_word,
	input  logic [pce_pkg::CNT_W-1:0]   byte_count,
	input  pce_pkg::pce_xpose_t         write_transpose,
	output logic [7:0]                  digit,
	output logic [pce_pkg::CNT_W-1:0]   remaining
);

	logic [31:0]               bytes_q;
	logic [pce_pkg::CNT_W-1:0] rem_q;

	assign digit     = bytes_q[31:24];
	assign remaining = rem_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bytes_q <= pce_pkg::order_bytes(data_word, byte_count, write_transpose);
		end else if (ctl.step) begin
			bytes_q <= {bytes_q[23:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= pce_pkg::clamp_count(byte_count);
		end else if (ctl.step) begin
			rem_q <= rem_q - 3'd1;
		end
	end

endmodule

// ===== rtl/pce_crc_core.sv =====
// crc register with one-byte fold step and result formatting
// depends on pce_pkg for the fold and format functions
module pce_crc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  pce_pkg::pce_ctl_t ctl,
	input  pce_pkg::pce_cfg_t regs,
	input  logic [7:0]        digit,
	output logic [31:0]       result
);

	logic [31:0] crc_q;
	logic [31:0] mask;

	assign mask   = regs.wide_mode ? pce_pkg::MASK32 : pce_pkg::MASK16;
	assign result = pce_pkg::format_result(crc_q, regs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.load) begin
			// width may have changed since the last word
			crc_q <= (ctl.start ? regs.seed_value : crc_q) & mask;
		end else if (ctl.step) begin
			crc_q <= pce_pkg::fold_byte(crc_q, digit, regs.polynomial & mask,
				regs.wide_mode);
		end
	end

endmodule

// ===== rtl/programmable_crc_engine.sv =====
// programmable crc engine, 16 or 32 bit, with input and result transposition
// an input beat loads the byte shifter, then the fold loop folds its bytes (0..4) one per cycle,
// and the result enters the output register once that register is free; no word is taken
// during a fold, but the next word is taken while the previous result waits in the output register
// reset: crc register cleared, registers to their defaults, no result pending
module programmable_crc_engine (
	input  logic      clk,
	input  logic      arst_n,
	pce_cfg_if.sink   cfg,
	pce_in_if.sink    data_in,
	pce_out_if.source crc_out
);

	`include "programmable_crc_engine_assert.svh"

	pce_pkg::pce_cfg_t         regs;
	pce_pkg::pce_ctl_t         ctl;
	pce_pkg::pce_state_t       state_q;
	pce_pkg::pce_state_t       state_nx;
	logic [7:0]                digit;
	logic [pce_pkg::CNT_W-1:0] remaining;
	logic [31:0]               result;
	logic                      in_beat;
	logic                      slot_free;
	logic                      out_load;
	logic                      out_valid_q;
	logic [31:0]               out_crc_q;

	pce_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pce_byte_shifter u_shift (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.data_word       (data_in.data_word),
		.byte_count      (data_in.byte_count),
		.write_transpose (regs.write_transpose),
		.digit           (digit),
		.remaining       (remaining)
	);

	pce_crc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.regs   (regs),
		.digit  (digit),
		.result (result)
	);

	assign in_beat   = data_in.valid & data_in.ready;
	assign slot_free = !out_valid_q || crc_out.ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pce_pkg::ST_IDLE: if (in_beat) state_nx = pce_pkg::ST_FOLD;
			pce_pkg::ST_FOLD: if (remaining == '0 && slot_free) state_nx = pce_pkg::ST_IDLE;
			default:          state_nx = pce_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		data_in.ready = 1'b0;
		ctl           = '0;
		out_load      = 1'b0;
		unique case (state_q)
			pce_pkg::ST_IDLE: begin
				data_in.ready = 1'b1;
				ctl.load      = data_in.valid;
				ctl.start     = data_in.start_block;
			end
			pce_pkg::ST_FOLD: begin
				ctl.step = (remaining != '0);
				out_load = (remaining == '0) && slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pce_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (crc_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_crc_q <= result;
		end
	end

	assign crc_out.valid     = out_valid_q;
	assign crc_out.crc_value = out_crc_q;

	`PCE_ASSERT_NEXT(a_beat_starts_fold, clk, arst_n, in_beat,
		state_q == pce_pkg::ST_FOLD && remaining <= pce_pkg::MAX_BYTES,
		"input beat did not start a fold of at most four bytes")
	`PCE_ASSERT_NEXT(a_no_early_exit, clk, arst_n,
		state_q == pce_pkg::ST_FOLD && remaining != '0,
		state_q == pce_pkg::ST_FOLD, "fold ended with bytes still pending")
	`PCE_ASSERT_SAME(a_load_needs_slot, clk, arst_n, out_load,
		!out_valid_q || crc_out.ready, "result overwrote a pending beat")
	`PCE_ASSERT_NEXT(a_narrow_result, clk, arst_n, out_load && !regs.wide_mode,
		out_crc_q[31:16] == 16'h0000, "16-bit result has upper bits set")

endmodule
